// File: rtl/tuce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tuce_pkg
// Shared widths, register indexes and defaults for the TCP/UDP checksum engine.
// ----------------------------------------------------------------------------
package tuce_pkg;

	localparam int BYTE_W     = 8;
	localparam int WORD_W     = 16;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int PROTO_W    = 8;
	localparam int COUNT_W    = 16;
	// pseudo-header constant part: four address halves plus protocol
	localparam int PCONST_W   = 19;
	// running sum + addend + length before folding
	localparam int TOTAL_W    = 19;

	localparam int LENGTH_BITS_DEFAULT = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PSEUDO_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_SUM    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_IP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL    = 3'd4;

	// ones' complement 16-bit add with end-around carry
	function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
	endfunction

endpackage
`default_nettype wire

// File: rtl/tcp_udp_checksum_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_udp_checksum_engine
// Internet checksum (RFC 1071) over a byte stream, with IPv4 pseudo-header.
// ----------------------------------------------------------------------------
// Throughput: one payload byte per clock, sustained, while the result side
//   takes results; a held result stalls the whole pipe for that cycle.
// Result path: the last byte passes the input register, the sum/length
//   register and the result register before its result shows in m_tdata.
// Reset (arst_n low): packet state, valids and config registers clear at
//   once; pseudo_mode comes up as 1, the other config registers as 0.
// ----------------------------------------------------------------------------
module tcp_udp_checksum_engine #(
	parameter int LENGTH_BITS = tuce_pkg::LENGTH_BITS_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_we,
	input  wire logic [tuce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tuce_pkg::CFG_W-1:0]     cfg_data,
	// byte stream in
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  wire logic                           s_tlast,   // last_byte
	// result out
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	output      logic [31:0]                    m_tdata    // [15:0] checksum,
	                                                       // [31:16] byte_count
);

	localparam int WORD_W   = tuce_pkg::WORD_W;
	localparam int BYTE_W   = tuce_pkg::BYTE_W;
	localparam int PCONST_W = tuce_pkg::PCONST_W;
	localparam int TOTAL_W  = tuce_pkg::TOTAL_W;
	localparam int COUNT_W  = tuce_pkg::COUNT_W;

	// ------------------------------------------------------------------
	// Configuration registers. Write only while the engine is idle; not enforced here.
	// ------------------------------------------------------------------
	logic                          pseudo_mode_q;
	logic [tuce_pkg::CFG_W-1:0]    seed_sum_q;
	logic [tuce_pkg::CFG_W-1:0]    source_ip_q;
	logic [tuce_pkg::CFG_W-1:0]    dest_ip_q;
	logic [tuce_pkg::PROTO_W-1:0]  protocol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pseudo_mode_q <= 1'b1;
			seed_sum_q    <= '0;
			source_ip_q   <= '0;
			dest_ip_q     <= '0;
			protocol_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tuce_pkg::REG_PSEUDO_MODE: pseudo_mode_q <= cfg_data[0];
				tuce_pkg::REG_SEED_SUM:    seed_sum_q    <= cfg_data;
				tuce_pkg::REG_SOURCE_IP:   source_ip_q   <= cfg_data;
				tuce_pkg::REG_DEST_IP:     dest_ip_q     <= cfg_data;
				tuce_pkg::REG_PROTOCOL:    protocol_q    <= cfg_data[tuce_pkg::PROTO_W-1:0];
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipe control: every stage moves together whenever the result
	// register is empty or being drained this cycle.
	// ------------------------------------------------------------------
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Per-packet state: bytes pair into big-endian words; a word is added
	// once its low byte arrives, or on a lone last byte (low byte zero).
	// ------------------------------------------------------------------
	logic [WORD_W-1:0]      running_sum_q;
	logic [BYTE_W-1:0]      held_high_q;
	logic                   odd_q;
	logic [LENGTH_BITS-1:0] bytes_seen_q;

	logic                   fire_s1;
	logic                   add_word;
	logic [WORD_W-1:0]      word;
	logic [WORD_W-1:0]      sum_next;
	logic [LENGTH_BITS-1:0] count_next;

	assign fire_s1    = valid_s1 && adv;
	assign add_word   = odd_q || last_s1;
	assign word       = odd_q ? {held_high_q, data_s1} : {data_s1, {BYTE_W{1'b0}}};
	assign sum_next   = add_word ? tuce_pkg::oc_add(running_sum_q, word) : running_sum_q;
	assign count_next = bytes_seen_q + {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			held_high_q   <= '0;
			odd_q         <= 1'b0;
			bytes_seen_q  <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				// packet done: start the next one clean
				running_sum_q <= '0;
				held_high_q   <= '0;
				odd_q         <= 1'b0;
				bytes_seen_q  <= '0;
			end else begin
				running_sum_q <= sum_next;
				held_high_q   <= odd_q ? '0 : data_s1;
				odd_q         <= !odd_q;
				bytes_seen_q  <= count_next;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: packet sum, length and the extra addend. The addend is the
	// unfolded pseudo-header constant part or the seed halves; folding
	// the full sum at the end gives the same ones' complement result.
	// ------------------------------------------------------------------
	logic                   valid_s2;
	logic [WORD_W-1:0]      sum_s2;
	logic [COUNT_W-1:0]     count_s2;
	logic                   mode_s2;
	logic [PCONST_W-1:0]    addend_s2;

	logic [PCONST_W-1:0]    pconst;
	logic [PCONST_W-1:0]    seed_part;

	assign pconst = PCONST_W'(source_ip_q[31:16]) + PCONST_W'(source_ip_q[15:0])
	              + PCONST_W'(dest_ip_q[31:16])   + PCONST_W'(dest_ip_q[15:0])
	              + PCONST_W'(protocol_q);
	assign seed_part = PCONST_W'(seed_sum_q[31:16]) + PCONST_W'(seed_sum_q[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2    <= sum_next;
			count_s2  <= COUNT_W'(count_next);
			mode_s2   <= pseudo_mode_q;
			addend_s2 <= pseudo_mode_q ? pconst : seed_part;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: final add, two end-around folds, complement.
	// ------------------------------------------------------------------
	logic [TOTAL_W-1:0] total;
	logic [WORD_W:0]    fold1;
	logic [WORD_W-1:0]  fold2;

	assign total = TOTAL_W'(sum_s2) + TOTAL_W'(addend_s2)
	             + (mode_s2 ? TOTAL_W'(count_s2) : '0);
	assign fold1 = {1'b0, total[WORD_W-1:0]}
	             + (WORD_W+1)'(total[TOTAL_W-1:WORD_W]);
	assign fold2 = fold1[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold1[WORD_W]};

	logic               out_valid_q;
	logic [WORD_W-1:0]  checksum_q;
	logic [COUNT_W-1:0] byte_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			checksum_q   <= ~fold2;
			byte_count_q <= count_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {byte_count_q, checksum_q};

endmodule
`default_nettype wire
